// File: src/adcd_pkg.sv
`default_nettype none
package adcd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [2:0]  AttrBaseHi = 3'b110;

  localparam logic [0:0] RegPaletteSelect = 1'b0;

  localparam logic [1:0] PalColor = 2'd0;
  localparam logic [1:0] PalDim   = 2'd1;
  localparam logic [1:0] PalGrey  = 2'd2;

  typedef struct packed {
    logic [7:0]  row;
    logic [4:0]  column;
    logic [7:0]  pixel_byte;
    logic [3:0]  fg_idx;
    logic [3:0]  bg_idx;
    logic [12:0] bitmap_address;
    logic [12:0] attribute_address;
  } cell_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam logic [23:0] PAL_COLOR [16] = '{
    24'h000000, 24'h0000ff, 24'hff0000, 24'hff00ff,
    24'h00ff00, 24'h00ffff, 24'hffff00, 24'hffffff,
    24'h000000, 24'h6060ff, 24'hff6060, 24'hff60ff,
    24'h60ff60, 24'h60ffff, 24'hffff60, 24'hffffff
  };

  localparam logic [23:0] PAL_DIM [16] = '{
    24'h000000, 24'h000080, 24'h800000, 24'h800080,
    24'h008000, 24'h008080, 24'h808000, 24'hffffff,
    24'h000000, 24'h6060c4, 24'hc46060, 24'hc460ff,
    24'h60c460, 24'h60c4c4, 24'hc4c460, 24'hffffff
  };

  localparam logic [23:0] PAL_GREY [16] = '{
    24'h000000, 24'h323232, 24'h5a5a5a, 24'haaaaaa,
    24'h464646, 24'h787878, 24'hc8c8c8, 24'hffffff,
    24'h000000, 24'h282828, 24'h505050, 24'ha0a0a0,
    24'h3c3c3c, 24'h6e6e6e, 24'hbebebe, 24'hffffff
  };

  // selector three falls back to greyscale
  function automatic logic [23:0] palette_rgb(input logic [1:0] sel, input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (sel)
      PalColor: rgb = PAL_COLOR[idx];
      PalDim:   rgb = PAL_DIM[idx];
      default:  rgb = PAL_GREY[idx];
    endcase
    return rgb;
  endfunction

endpackage
`default_nettype wire

// File: src/adcd_front.sv
`default_nettype none
module adcd_front (
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [7:0]        in_row,
  input  wire logic [4:0]        in_column,
  input  wire logic [7:0]        in_pixel_byte,
  input  wire logic [7:0]        in_attr_byte,
  input  wire logic              in_flash_phase,
  input  wire adcd_pkg::q_status_t q_status,
  output logic                   push,
  output adcd_pkg::cell_t        push_cell
);

  logic       swap;
  logic       bright;
  logic [2:0] ink;
  logic [2:0] paper;

  assign busy   = q_status.full;
  assign push   = start && !q_status.full;
  assign swap   = in_attr_byte[7] & in_flash_phase;
  assign bright = in_attr_byte[6];
  assign paper  = in_attr_byte[5:3];
  assign ink    = in_attr_byte[2:0];

  always_comb begin
    push_cell.row               = in_row;
    push_cell.column            = in_column;
    push_cell.pixel_byte        = in_pixel_byte;
    push_cell.fg_idx            = {bright, swap ? paper : ink};
    push_cell.bg_idx            = {bright, swap ? ink : paper};
    push_cell.bitmap_address    = {in_row[7:6], in_row[2:0], in_row[5:3], in_column};
    push_cell.attribute_address = {adcd_pkg::AttrBaseHi, in_row[7:3], in_column};
  end

endmodule
`default_nettype wire

// File: src/adcd_queue.sv
`default_nettype none
module adcd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire adcd_pkg::cell_t   push_cell,
  input  wire logic              pop,
  output adcd_pkg::cell_t        head,
  output adcd_pkg::q_status_t    status
);

  adcd_pkg::cell_t mem_r [adcd_pkg::QueueDepth];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == 2'(adcd_pkg::QueueDepth));
  assign status.empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cell;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(adcd_pkg::QueueDepth)) else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: src/adcd_back.sv
`default_nettype none
module adcd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        palette_sel,
  input  wire adcd_pkg::cell_t   head,
  input  wire adcd_pkg::q_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  output logic [7:0]             out_pixel_x,
  output logic [7:0]             out_pixel_y,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic [12:0]            out_bitmap_address,
  output logic [12:0]            out_attribute_address,
  output logic                   out_last_pixel
);

  adcd_pkg::cell_t cur_r;
  logic            active_r, active_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            last;
  logic            bit_set;
  logic [23:0]     rgb;

  logic        valid_r;
  logic [7:0]  x_r, y_r, red_r, green_r, blue_r;
  logic [12:0] bmp_r, aad_r;
  logic        last_r;

  assign last    = (cnt_r == 3'd7);
  assign pop     = !q_status.empty && (!active_r || last);
  assign bit_set = cur_r.pixel_byte[3'd7 - cnt_r];
  assign rgb     = adcd_pkg::palette_rgb(palette_sel, bit_set ? cur_r.fg_idx : cur_r.bg_idx);

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (pop) begin
      active_nxt = 1'b1;
      cnt_nxt    = 3'd0;
    end else if (active_r) begin
      cnt_nxt = cnt_r + 3'd1;
      if (last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= 3'd0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      valid_r  <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (active_r) begin
      x_r     <= {cur_r.column, cnt_r};
      y_r     <= cur_r.row;
      red_r   <= rgb[23:16];
      green_r <= rgb[15:8];
      blue_r  <= rgb[7:0];
      bmp_r   <= cur_r.bitmap_address;
      aad_r   <= cur_r.attribute_address;
      last_r  <= last;
    end
  end

  assign out_valid             = valid_r;
  assign out_pixel_x           = x_r;
  assign out_pixel_y           = y_r;
  assign out_red               = red_r;
  assign out_green             = green_r;
  assign out_blue              = blue_r;
  assign out_bitmap_address    = bmp_r;
  assign out_attribute_address = aad_r;
  assign out_last_pixel        = last_r;

`ifndef SYNTHESIS
  a_cell_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_valid) else $error("gap inside a cell");
  a_x_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_pixel_x == $past(out_pixel_x) + 8'd1)
    else $error("pixel_x did not advance");
  a_last_lane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel == (out_pixel_x[2:0] == 3'd7)))
    else $error("last_pixel misplaced");
`endif

endmodule
`default_nettype wire

// File: src/attribute_display_cell_decoder.sv
`default_nettype none
// An accepted item goes through a queue entry and the serializer's cell register to the output registers.
// The pixel serializer emits one pixel per cycle while it holds an item, eight pixels per item.
// A two-entry queue between classifier and serializer takes items while a cell drains;
// busy is high only while the queue is full. The receiver cannot stall.
// Synchronous active-low reset empties the queue, idles the serializer, palette_select = 0.
module attribute_display_cell_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_row,
  input  wire logic [4:0]  in_column,
  input  wire logic [7:0]  in_pixel_byte,
  input  wire logic [7:0]  in_attr_byte,
  input  wire logic        in_flash_phase,
  output logic             out_valid,
  output logic [7:0]       out_pixel_x,
  output logic [7:0]       out_pixel_y,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [12:0]      out_bitmap_address,
  output logic [12:0]      out_attribute_address,
  output logic             out_last_pixel,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  adcd_pkg::cell_t     push_cell;
  adcd_pkg::cell_t     head;
  adcd_pkg::q_status_t q_status;
  logic                push;
  logic                pop;
  logic [1:0]          palette_sel_r;
  logic                reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == adcd_pkg::RegPaletteSelect);
  assign prdata  = reg_hit ? {30'd0, palette_sel_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_sel_r <= adcd_pkg::PalColor;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      palette_sel_r <= pwdata[1:0];
    end
  end

  adcd_front u_front (
    .start          (start),
    .busy           (busy),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_pixel_byte  (in_pixel_byte),
    .in_attr_byte   (in_attr_byte),
    .in_flash_phase (in_flash_phase),
    .q_status       (q_status),
    .push           (push),
    .push_cell      (push_cell)
  );

  adcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cell (push_cell),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  adcd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .palette_sel           (palette_sel_r),
    .head                  (head),
    .q_status              (q_status),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_pixel_x           (out_pixel_x),
    .out_pixel_y           (out_pixel_y),
    .out_red               (out_red),
    .out_green             (out_green),
    .out_blue              (out_blue),
    .out_bitmap_address    (out_bitmap_address),
    .out_attribute_address (out_attribute_address),
    .out_last_pixel        (out_last_pixel)
  );

endmodule
`default_nettype wire

// File: dv/attribute_display_cell_decoder_test.sv
`timescale 1ns / 100ps
module attribute_display_cell_decoder_test;

  localparam logic [1:0] PalGreyHigh = 2'd3;
  localparam int         PhaseCells  = 33;

  localparam logic [23:0] RGB_TABLE [3][16] = '{
    '{24'h000000, 24'h0000ff, 24'hff0000, 24'hff00ff,
      24'h00ff00, 24'h00ffff, 24'hffff00, 24'hffffff,
      24'h000000, 24'h6060ff, 24'hff6060, 24'hff60ff,
      24'h60ff60, 24'h60ffff, 24'hffff60, 24'hffffff},
    '{24'h000000, 24'h000080, 24'h800000, 24'h800080,
      24'h008000, 24'h008080, 24'h808000, 24'hffffff,
      24'h000000, 24'h6060c4, 24'hc46060, 24'hc460ff,
      24'h60c460, 24'h60c4c4, 24'hc4c460, 24'hffffff},
    '{24'h000000, 24'h323232, 24'h5a5a5a, 24'haaaaaa,
      24'h464646, 24'h787878, 24'hc8c8c8, 24'hffffff,
      24'h000000, 24'h282828, 24'h505050, 24'ha0a0a0,
      24'h3c3c3c, 24'h6e6e6e, 24'hbebebe, 24'hffffff}
  };

  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [12:0] bitmap_address;
    logic [12:0] attribute_address;
    logic        last_pixel;
  } pixel_t;

  class cell_scoreboard;
    pixel_t     pending[$];
    logic [1:0] palette;
    int         mismatches;
    int         checked;

    function new();
      palette    = adcd_pkg::PalColor;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void note_cell(logic [7:0] row, logic [4:0] column, logic [7:0] pix,
                            logic [7:0] attr, logic phase);
      logic        swap;
      logic [1:0]  tbl;
      logic [12:0] b;
      logic [12:0] bmp;
      logic [12:0] aad;
      logic [3:0]  idx;
      logic [23:0] rgb;
      pixel_t      p;
      swap = attr[7] & phase;
      tbl  = (palette > adcd_pkg::PalGrey) ? adcd_pkg::PalGrey : palette;
      b    = {row, column};
      bmp  = {b[12:11], b[7:5], b[10:8], b[4:0]};
      aad  = 13'd6144 + {row[7:3], 5'd0} + 13'(column);
      for (int k = 0; k < 8; k++) begin
        idx = {attr[6], (pix[7-k] ^ swap) ? attr[2:0] : attr[5:3]};
        rgb = RGB_TABLE[tbl][idx];
        p.pixel_x           = {column, 3'(k)};
        p.pixel_y           = row;
        p.red               = rgb[23:16];
        p.green             = rgb[15:8];
        p.blue              = rgb[7:0];
        p.bitmap_address    = bmp;
        p.attribute_address = aad;
        p.last_pixel        = (k == 7);
        pending.push_back(p);
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task cmp_field(string name, logic [12:0] got, logic [12:0] want, pixel_t ctx);
      if (got !== want)
        report_mismatch($sformatf("x=%0d y=%0d %s got %0d want %0d",
                                  ctx.pixel_x, ctx.pixel_y, name, got, want));
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("pixel x=%0d y=%0d with no item pending",
                                  got.pixel_x, got.pixel_y));
        return;
      end
      want = pending.pop_front();
      checked++;
      cmp_field("pixel_x", 13'(got.pixel_x), 13'(want.pixel_x), want);
      cmp_field("pixel_y", 13'(got.pixel_y), 13'(want.pixel_y), want);
      cmp_field("red", 13'(got.red), 13'(want.red), want);
      cmp_field("green", 13'(got.green), 13'(want.green), want);
      cmp_field("blue", 13'(got.blue), 13'(want.blue), want);
      cmp_field("bitmap_address", got.bitmap_address, want.bitmap_address, want);
      cmp_field("attribute_address", got.attribute_address, want.attribute_address, want);
      cmp_field("last_pixel", 13'(got.last_pixel), 13'(want.last_pixel), want);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_row;
  logic [4:0]  in_column;
  logic [7:0]  in_pixel_byte;
  logic [7:0]  in_attr_byte;
  logic        in_flash_phase;
  logic        out_valid;
  logic [7:0]  out_pixel_x;
  logic [7:0]  out_pixel_y;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [12:0] out_bitmap_address;
  logic [12:0] out_attribute_address;
  logic        out_last_pixel;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cell_scoreboard sb;
  pixel_t         seen;
  int             cells_sent = 0;
  int             settings_used = 0;

  attribute_display_cell_decoder DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_row                (in_row),
    .in_column             (in_column),
    .in_pixel_byte         (in_pixel_byte),
    .in_attr_byte          (in_attr_byte),
    .in_flash_phase        (in_flash_phase),
    .out_valid             (out_valid),
    .out_pixel_x           (out_pixel_x),
    .out_pixel_y           (out_pixel_y),
    .out_red               (out_red),
    .out_green             (out_green),
    .out_blue              (out_blue),
    .out_bitmap_address    (out_bitmap_address),
    .out_attribute_address (out_attribute_address),
    .out_last_pixel        (out_last_pixel),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      seen = '{out_pixel_x, out_pixel_y, out_red, out_green, out_blue,
               out_bitmap_address, out_attribute_address, out_last_pixel};
      sb.check_pixel(seen);
    end
  end

  // called at a rising edge; returns at the edge that took the item
  task send_cell(logic [7:0] row, logic [4:0] column, logic [7:0] pix,
                 logic [7:0] attr, logic phase);
    start          <= 1'b1;
    in_row         <= row;
    in_column      <= column;
    in_pixel_byte  <= pix;
    in_attr_byte   <= attr;
    in_flash_phase <= phase;
    do @(negedge clk); while (busy !== 1'b0);
    sb.note_cell(row, column, pix, attr, phase);
    cells_sent++;
    @(posedge clk);
  endtask

  task idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task send_random_cell(bit no_gaps);
    logic [7:0] row;
    row = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(192, 255))
                                      : 8'($urandom_range(0, 191));
    send_cell(row, 5'($urandom_range(0, 31)), 8'($urandom), 8'($urandom),
              1'($urandom_range(0, 1)));
    if (!no_gaps && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 3));
  endtask

  task drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (sb.pending.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  // write then read back the palette register
  task cfg_write(logic [1:0] value);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {adcd_pkg::RegPaletteSelect, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    @(posedge clk);
    sb.palette = value;
    settings_used++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(value))
      sb.report_mismatch($sformatf("palette_select read %0d want %0d", rd, value));
  endtask

  initial begin
    logic [1:0] phases [6];
    phases = '{adcd_pkg::PalDim, PalGreyHigh, adcd_pkg::PalColor,
               adcd_pkg::PalGrey, PalGreyHigh, adcd_pkg::PalDim};
    sb = new();
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_row         <= '0;
    in_column      <= '0;
    in_pixel_byte  <= '0;
    in_attr_byte   <= '0;
    in_flash_phase <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cells at the reset palette
    send_cell(8'd0, 5'd0, 8'h00, 8'h00, 1'b0);
    send_cell(8'd191, 5'd31, 8'hff, 8'hff, 1'b1);
    send_cell(8'd191, 5'd31, 8'hff, 8'hff, 1'b0);
    send_cell(8'd192, 5'd0, 8'haa, 8'h38, 1'b0);
    send_cell(8'd255, 5'd31, 8'h55, 8'h07, 1'b1);
    idle_cycles(2);
    send_cell(8'd7, 5'd1, 8'h81, 8'h8f, 1'b1);
    send_cell(8'd8, 5'd2, 8'h81, 8'h8f, 1'b0);
    send_cell(8'd63, 5'd16, 8'h0f, 8'h78, 1'b0);
    idle_cycles(1);
    send_cell(8'd64, 5'd15, 8'hf0, 8'h7f, 1'b1);
    send_cell(8'd127, 5'd8, 8'h3c, 8'h40, 1'b0);
    idle_cycles(3);
    send_cell(8'd128, 5'd23, 8'hc3, 8'hc0, 1'b1);
    send_cell(8'd100, 5'd10, 8'h01, 8'h80, 1'b1);
    send_cell(8'd200, 5'd5, 8'h80, 8'hb9, 1'b0);
    send_cell(8'd165, 5'd26, 8'h5a, 8'h46, 1'b1);
    drain();

    foreach (phases[i]) begin
      cfg_write(phases[i]);
      repeat (PhaseCells) send_random_cell(i == 5);
      drain();
    end

    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d pixels never arrived", sb.pending.size()));
    $display("sent %0d cells, checked %0d pixels over %0d palette writes",
             cells_sent, sb.checked, settings_used);
    $display("%0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
